[src/pdf_pkg.sv]
`default_nettype none

package pdf_pkg;

    localparam int unsigned CACHE_ENTRIES_DEF = 16;
    localparam int unsigned KEY_W             = 32;
    localparam int unsigned TIME_W            = 32;
    localparam logic [TIME_W-1:0] LIFETIME_RESET = 32'd30000;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] now;
    } query_t;

    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] tstamp;
    } entry_t;

endpackage

`default_nettype wire

[src/pdf_cell.sv]
`default_nettype none

module pdf_cell
    import pdf_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              shift_en,
    input  wire logic [TIME_W-1:0] lifetime,
    input  wire query_t            query,
    input  wire entry_t            prev_entry,
    output entry_t                 entry,
    output logic                   match
);

    logic              valid_reg;
    logic              valid_next;
    logic [KEY_W-1:0]  key_reg;
    logic [KEY_W-1:0]  key_next;
    logic [TIME_W-1:0] tstamp_reg;
    logic [TIME_W-1:0] tstamp_next;
    logic [TIME_W-1:0] age;

    always_comb
    begin
        valid_next  = valid_reg;
        key_next    = key_reg;
        tstamp_next = tstamp_reg;
        if (shift_en)
        begin
            valid_next  = prev_entry.valid;
            key_next    = prev_entry.key;
            tstamp_next = prev_entry.tstamp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        tstamp_reg <= tstamp_next;
    end

    // wrapping age of the stored entry
    assign age   = query.now - tstamp_reg;
    assign match = valid_reg && (key_reg == query.key) && (age <= lifetime);

    assign entry.valid  = valid_reg;
    assign entry.key    = key_reg;
    assign entry.tstamp = tstamp_reg;

endmodule

`default_nettype wire

[src/packet_dedup_filter.sv]
`default_nettype none

// channel  | signals                               | accepted when
// ---------+---------------------------------------+--------------------------
// in       | in_valid, in_stall, sender, seq,      | in_valid && !in_stall
//          | packet_type, now_ms                   |
// out      | out_valid, out_stall, duplicate       | out_valid && !out_stall
// cfg      | cfg_write, cfg_data                   | cfg_write
//
// one request at a time: the accepted key is registered, then compared against
// every cell of the chain and shifted in on a miss
// the result sits in an output register, so a new request is taken while it waits
// a request is held while the output register is full and stalled
// reset clears the valid bit of every cell and sets the lifetime to 30000 ms
// the chain itself keeps insertion order: the oldest entry drops off the end

module packet_dedup_filter
    import pdf_pkg::*;
#(
    parameter int unsigned CACHE_ENTRIES = CACHE_ENTRIES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [15:0] sender,
    input  wire logic [7:0]  seq,
    input  wire logic [7:0]  packet_type,
    input  wire logic [31:0] now_ms,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             duplicate,
    input  wire logic        cfg_write,
    input  wire logic [31:0] cfg_data
);

    logic [TIME_W-1:0]      lifetime_reg;
    logic [TIME_W-1:0]      lifetime_next;
    logic                   query_valid_reg;
    logic                   query_valid_next;
    query_t                 query_reg;
    query_t                 query_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   dup_reg;
    logic                   dup_next;
    logic                   in_fire;
    logic                   done;
    logic                   hit;
    logic                   shift_en;
    logic [CACHE_ENTRIES-1:0] match_vec;
    entry_t                 chain [CACHE_ENTRIES+1];

    assign in_fire = in_valid && !in_stall;
    assign done    = query_valid_reg && (!out_valid_reg || !out_stall);
    assign hit     = |match_vec;
    assign shift_en = done && !hit;

    assign chain[0].valid  = 1'b1;
    assign chain[0].key    = query_reg.key;
    assign chain[0].tstamp = query_reg.now;

    for (genvar i = 0; i < CACHE_ENTRIES; i++)
    begin : g_cell
        pdf_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift_en   (shift_en),
            .lifetime   (lifetime_reg),
            .query      (query_reg),
            .prev_entry (chain[i]),
            .entry      (chain[i+1]),
            .match      (match_vec[i])
        );
    end

    always_comb
    begin
        lifetime_next    = lifetime_reg;
        query_valid_next = query_valid_reg;
        query_next       = query_reg;
        out_valid_next   = out_valid_reg;
        dup_next         = dup_reg;
        if (cfg_write)
        begin
            lifetime_next = cfg_data;
        end
        if (in_fire)
        begin
            query_valid_next = 1'b1;
            query_next.key   = {sender, seq, packet_type};
            query_next.now   = now_ms;
        end
        else if (done)
        begin
            query_valid_next = 1'b0;
        end
        if (done)
        begin
            out_valid_next = 1'b1;
            dup_next       = hit;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lifetime_reg    <= LIFETIME_RESET;
            query_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            lifetime_reg    <= lifetime_next;
            query_valid_reg <= query_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        query_reg <= query_next;
        dup_reg   <= dup_next;
    end

    assign in_stall  = query_valid_reg;
    assign out_valid = out_valid_reg;
    assign duplicate = dup_reg;

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> query_valid_reg)
        else $error("accepted request not held");

    a_miss_inserts: assert property (@(posedge clk) disable iff (!rst_n)
        shift_en |=> chain[1].valid && chain[1].key == $past(query_reg.key)
                     && chain[1].tstamp == $past(query_reg.now))
        else $error("missed key not inserted at the chain head");

    a_hit_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        done && hit |=> $stable(chain[1].key) && $stable(chain[1].tstamp))
        else $error("duplicate request changed the cache");

    a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> out_valid_reg && !query_valid_reg && dup_reg == $past(hit))
        else $error("finished request gave no result");

    a_full_stays: assert property (@(posedge clk) disable iff (!rst_n)
        chain[CACHE_ENTRIES].valid |=> chain[CACHE_ENTRIES].valid)
        else $error("last cell lost its entry");

endmodule

`default_nettype wire
